// ----- rtl/core/rae_pkg.sv -----
package rae_pkg;

  // Instruction modes
  localparam logic [2:0] MODE_CMOV = 3'd0;
  localparam logic [2:0] MODE_ADD  = 3'd1;
  localparam logic [2:0] MODE_MUL  = 3'd2;
  localparam logic [2:0] MODE_DIV  = 3'd3;
  localparam logic [2:0] MODE_NAND = 3'd4;
  localparam logic [2:0] MODE_LDI  = 3'd5;

  localparam int unsigned REG_COUNT = 8;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned IMM_W     = 25;
  localparam int unsigned DIV_CNT_W = 6;

  typedef struct packed {
    logic [2:0]       mode;
    logic [IDX_W-1:0] dest_index;
    logic [IDX_W-1:0] src_b_index;
    logic [IDX_W-1:0] src_c_index;
    logic [IMM_W-1:0] immediate;
  } in_t;

  typedef struct packed {
    logic              wrote;
    logic [DATA_W-1:0] written_value;
    logic              divide_by_zero;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture instruction and read operands
    logic div_start;  // launch the iterative divider
    logic finish;     // write back and present the result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_needed; // divide with a nonzero divisor
    logic div_done;   // quotient is ready
  } status_t;

endpackage

// ----- rtl/core/rae_div.sv -----
module rae_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [rae_pkg::DATA_W-1:0]       dividend,
  input  logic [rae_pkg::DATA_W-1:0]       divisor,
  output logic [rae_pkg::DATA_W-1:0]       quotient,
  output logic                             done
);

  logic [rae_pkg::DATA_W-1:0]    quo_r, quo_nxt;
  logic [rae_pkg::DATA_W-1:0]    rem_r, rem_nxt;
  logic [rae_pkg::DATA_W-1:0]    dsr_r, dsr_nxt;
  logic [rae_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          run_r, run_nxt;
  logic [rae_pkg::DATA_W:0]      trial;

  // One restoring step per cycle: shift in the next dividend bit and try a subtract
  always_comb begin
    trial   = {rem_r, quo_r[rae_pkg::DATA_W-1]} - {1'b0, dsr_r};
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
      cnt_nxt = rae_pkg::DIV_CNT_W'(rae_pkg::DATA_W);
      run_nxt = 1'b1;
    end else if (run_r && (cnt_r != '0)) begin
      cnt_nxt = cnt_r - rae_pkg::DIV_CNT_W'(1);
      if (!trial[rae_pkg::DATA_W]) begin
        rem_nxt = trial[rae_pkg::DATA_W-1:0];
        quo_nxt = {quo_r[rae_pkg::DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[rae_pkg::DATA_W-2:0], quo_r[rae_pkg::DATA_W-1]};
        quo_nxt = {quo_r[rae_pkg::DATA_W-2:0], 1'b0};
      end
    end else if (run_r) begin
      run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
      run_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      run_r <= run_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = run_r && (cnt_r == '0);

endmodule

// ----- rtl/core/rae_ctrl.sv -----
module rae_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output rae_pkg::cmd_t    cmd,
  input  rae_pkg::status_t status
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0] state_r, state_nxt;

  // Sequence one instruction: read, execute, optionally iterate the divider
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.div_needed) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ----- rtl/core/rae_dp.sv -----
module rae_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  rae_pkg::in_t      in_data,
  input  rae_pkg::cmd_t     cmd,
  output rae_pkg::status_t  status,
  output logic              out_valid,
  output rae_pkg::out_t     out_data
);

  logic [rae_pkg::DATA_W-1:0]    mem [rae_pkg::REG_COUNT];
  logic [rae_pkg::REG_COUNT-1:0] vld_r;
  rae_pkg::in_t                  instr_r;
  logic [rae_pkg::DATA_W-1:0]    bv_r, cv_r;
  logic                          out_valid_r;
  rae_pkg::out_t                 out_r, res;
  logic [rae_pkg::DATA_W-1:0]    quotient;
  logic                          div_done;
  logic                          c_zero;

  // Capture the instruction and read both operands; unwritten registers read as zero
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      instr_r <= in_data;
      bv_r    <= vld_r[in_data.src_b_index] ? mem[in_data.src_b_index] : '0;
      cv_r    <= vld_r[in_data.src_c_index] ? mem[in_data.src_c_index] : '0;
    end
  end

  assign c_zero = (cv_r == '0);

  rae_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (bv_r),
    .divisor  (cv_r),
    .quotient (quotient),
    .done     (div_done)
  );

  assign status.div_needed = (instr_r.mode == rae_pkg::MODE_DIV) && !c_zero;
  assign status.div_done   = div_done;

  // Form the result of the current instruction
  always_comb begin
    res = '0;
    unique case (instr_r.mode)
      rae_pkg::MODE_CMOV: begin
        if (!c_zero) begin
          res.wrote         = 1'b1;
          res.written_value = bv_r;
        end
      end
      rae_pkg::MODE_ADD: begin
        res.wrote         = 1'b1;
        res.written_value = bv_r + cv_r;
      end
      rae_pkg::MODE_MUL: begin
        res.wrote         = 1'b1;
        res.written_value = bv_r * cv_r;
      end
      rae_pkg::MODE_DIV: begin
        if (c_zero) begin
          res.divide_by_zero = 1'b1;
        end else begin
          res.wrote         = 1'b1;
          res.written_value = quotient;
        end
      end
      rae_pkg::MODE_NAND: begin
        res.wrote         = 1'b1;
        res.written_value = ~(bv_r & cv_r);
      end
      rae_pkg::MODE_LDI: begin
        res.wrote         = 1'b1;
        res.written_value = {{(rae_pkg::DATA_W-rae_pkg::IMM_W){1'b0}}, instr_r.immediate};
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Write back register A
  always_ff @(posedge clk) begin
    if (cmd.finish && res.wrote) begin
      mem[instr_r.dest_index] <= res.written_value;
    end
  end

  // Track written registers and strobe the result for one cycle
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r <= res;
    end
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.finish && res.wrote) begin
        vld_r[instr_r.dest_index] <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/core/register_alu_execute.sv -----
// The accepting edge captures the instruction and reads its operands; a divide with a nonzero
// divisor then launches the divider, which runs 32 restoring steps, one bit per cycle.
// The result is then registered; a new instruction is accepted only while busy is low.
// out_valid pulses for a single cycle; out_data holds results until replaced; no stall input.
// Reset (rst_n low, synchronous) idles the controller and makes all eight registers read zero.
module register_alu_execute (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rae_pkg::in_t  in_data,
  output logic          out_valid,
  output rae_pkg::out_t out_data
);

  rae_pkg::cmd_t    cmd;
  rae_pkg::status_t status;
  logic             busy_int;

  rae_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy_int),
    .cmd    (cmd),
    .status (status)
  );

  rae_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign busy = busy_int;

endmodule
